// ===== rtl/core/sync_frame_receiver_checksum_core_defines.svh =====
// Assertion helpers for the receiver core.
`ifndef SYNC_FRAME_RECEIVER_CHECKSUM_CORE_DEFINES_SVH
`define SYNC_FRAME_RECEIVER_CHECKSUM_CORE_DEFINES_SVH

// cond must hold at every edge out of reset
`define SFR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// same-cycle implication
`define SFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sfr_pkg.sv =====
package sfr_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'hAF;
    localparam logic [7:0] FOOT_BYTE  = 8'hFA;
    localparam logic       REQ_RX     = 1'b0;
    localparam logic       REQ_CLEAR  = 1'b1;
    localparam int         MEM_AW_MAX = 6;

    typedef struct packed {
        logic [7:0] device_type;
        logic [7:0] command;
        logic [7:0] valid_length;
    } frame_hdr_t;

    typedef struct packed {
        logic                  en;
        logic [MEM_AW_MAX-1:0] addr;
        logic [7:0]            data;
    } payload_wr_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_READ,
        BACK_OUT
    } back_state_t;

endpackage

// ===== rtl/core/sfr_front.sv =====
module sfr_front #(
    parameter int DATA_BYTES = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [7:0]           s_rx_byte,
    input  logic                 emit_busy,
    output sfr_pkg::payload_wr_t payload_wr,
    output logic                 hdr_push,
    output sfr_pkg::frame_hdr_t  hdr_data
);

    localparam int FRAME_LEN = DATA_BYTES + 8;
    localparam int SUM_POS   = DATA_BYTES + 5;
    localparam int PW        = $clog2(FRAME_LEN + 1);

    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    sum_reg, sum_next;
    logic          pending_reg, pending_next;
    logic [7:0]    type_reg, type_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    csum_reg, csum_next;
    logic          foot_ok_reg, foot_ok_next;

    logic [PW-1:0] pos_eff;
    logic          accept;
    logic          is_byte;
    logic          good;
    logic          in_payload;

    assign s_ready = !(emit_busy && pos_reg >= PW'(5) && pos_reg < PW'(SUM_POS));
    assign accept  = s_valid && s_ready;
    assign pos_eff = (pos_reg >= PW'(FRAME_LEN)) ? '0 : pos_reg;
    assign is_byte = accept && (s_req_type == sfr_pkg::REQ_RX) && !pending_reg;
    assign good    = (csum_reg == sum_reg) && foot_ok_reg && (s_rx_byte == sfr_pkg::FOOT_BYTE);
    assign in_payload = (pos_eff >= PW'(5)) && (pos_eff < PW'(SUM_POS));

    always_comb begin
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        pending_next = pending_reg;
        type_next    = type_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        csum_next    = csum_reg;
        foot_ok_next = foot_ok_reg;
        hdr_push     = 1'b0;
        if (accept && s_req_type == sfr_pkg::REQ_CLEAR) begin
            pending_next = 1'b0;
        end else if (is_byte) begin
            if (pos_eff < PW'(2) && s_rx_byte != sfr_pkg::SYNC_BYTE) begin
                pos_next = '0;
                sum_next = '0;
            end else begin
                if (pos_eff < PW'(SUM_POS)) sum_next = sum_reg + s_rx_byte;
                if (pos_eff == PW'(2)) type_next = s_rx_byte;
                if (pos_eff == PW'(3)) cmd_next = s_rx_byte;
                if (pos_eff == PW'(4)) len_next = s_rx_byte;
                if (pos_eff == PW'(SUM_POS)) csum_next = s_rx_byte;
                if (pos_eff == PW'(SUM_POS + 1)) begin
                    foot_ok_next = (s_rx_byte == sfr_pkg::FOOT_BYTE);
                end
                if (pos_eff == PW'(FRAME_LEN - 1)) begin
                    pos_next = '0;
                    sum_next = '0;
                    if (good) begin
                        pending_next = 1'b1;
                        hdr_push     = 1'b1;
                    end
                end else begin
                    pos_next = pos_eff + PW'(1);
                end
            end
        end
    end

    always_comb begin
        payload_wr.en   = is_byte && in_payload;
        payload_wr.addr = sfr_pkg::MEM_AW_MAX'(pos_eff - PW'(5));
        payload_wr.data = s_rx_byte;
        hdr_data.device_type  = type_reg;
        hdr_data.command      = cmd_reg;
        hdr_data.valid_length = len_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            sum_reg     <= '0;
            pending_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            pending_reg <= pending_next;
        end
        type_reg    <= type_next;
        cmd_reg     <= cmd_next;
        len_reg     <= len_next;
        csum_reg    <= csum_next;
        foot_ok_reg <= foot_ok_next;
    end

endmodule

// ===== rtl/core/sfr_fifo.sv =====
module sfr_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  sfr_pkg::frame_hdr_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output sfr_pkg::frame_hdr_t pop_data
);

    sfr_pkg::frame_hdr_t entry_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/sfr_back.sv =====
module sfr_back #(
    parameter int DATA_BYTES = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sfr_pkg::payload_wr_t payload_wr,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  sfr_pkg::frame_hdr_t  q_data,
    output logic                 busy,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_device_type,
    output logic [7:0]           m_command,
    output logic [7:0]           m_valid_length,
    output logic [4:0]           m_byte_index,
    output logic [7:0]           m_payload_byte,
    output logic                 m_last
);

    localparam int AW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

    logic [7:0] mem [DATA_BYTES];
    logic [7:0] rdata_reg;

    sfr_pkg::back_state_t state_reg, state_next;
    sfr_pkg::frame_hdr_t  hdr_reg, hdr_next;
    logic [AW-1:0]        idx_reg, idx_next;

    logic                 out_valid_reg, out_valid_next;
    sfr_pkg::frame_hdr_t  out_hdr_reg, out_hdr_next;
    logic [4:0]           out_index_reg, out_index_next;
    logic [7:0]           out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;

    logic       out_free;
    logic       load;
    logic       at_last;
    logic [7:0] idx_wide;

    assign out_free = !out_valid_reg || m_ready;
    assign at_last  = (idx_reg == AW'(DATA_BYTES - 1));
    assign idx_wide = 8'(idx_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sfr_pkg::BACK_IDLE: if (q_valid) state_next = sfr_pkg::BACK_READ;
            sfr_pkg::BACK_READ: state_next = sfr_pkg::BACK_OUT;
            sfr_pkg::BACK_OUT: begin
                if (out_free) state_next = at_last ? sfr_pkg::BACK_IDLE : sfr_pkg::BACK_READ;
            end
            default: state_next = sfr_pkg::BACK_IDLE;
        endcase
    end

    always_comb begin
        q_ready = (state_reg == sfr_pkg::BACK_IDLE);
        busy    = (state_reg != sfr_pkg::BACK_IDLE);
        load    = (state_reg == sfr_pkg::BACK_OUT) && out_free;
        hdr_next = hdr_reg;
        idx_next = idx_reg;
        if (q_valid && q_ready) begin
            hdr_next = q_data;
            idx_next = '0;
        end else if (load && !at_last) begin
            idx_next = idx_reg + AW'(1);
        end
        out_hdr_next   = out_hdr_reg;
        out_index_next = out_index_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_hdr_next   = hdr_reg;
            out_index_next = idx_wide[4:0];
            out_data_next  = rdata_reg;
            out_last_next  = at_last;
        end else begin
            out_valid_next = out_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (payload_wr.en) mem[payload_wr.addr[AW-1:0]] <= payload_wr.data;
        rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sfr_pkg::BACK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        hdr_reg       <= hdr_next;
        idx_reg       <= idx_next;
        out_hdr_reg   <= out_hdr_next;
        out_index_reg <= out_index_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_device_type  = out_hdr_reg.device_type;
    assign m_command      = out_hdr_reg.command;
    assign m_valid_length = out_hdr_reg.valid_length;
    assign m_byte_index   = out_index_reg;
    assign m_payload_byte = out_data_reg;
    assign m_last         = out_last_reg;

endmodule

// ===== rtl/core/sync_frame_receiver_checksum_core.sv =====
// Sync-framed serial receiver. Each word is either a received byte or a request to
// clear the frame-pending flag; bytes build a frame of AF AF, type, command, length,
// DATA_BYTES payload bytes, an 8-bit additive checksum and an FA FA footer. A good
// frame sets the pending flag (bytes are dropped until a clear) and comes out as
// DATA_BYTES words, the final one marked with m_last. Input words are taken one per
// cycle while s_ready is high. Each result passes through the emitter's two steps
// (payload memory read, then output register load); a payload byte of the next
// frame waits while the previous frame still reads the memory.
`include "sync_frame_receiver_checksum_core_defines.svh"

module sync_frame_receiver_checksum_core #(
    parameter int DATA_BYTES = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_device_type,
    output logic [7:0] m_command,
    output logic [7:0] m_valid_length,
    output logic [4:0] m_byte_index,
    output logic [7:0] m_payload_byte,
    output logic       m_last
);

    sfr_pkg::payload_wr_t payload_wr;
    sfr_pkg::frame_hdr_t  hdr_data;
    sfr_pkg::frame_hdr_t  q_data;
    logic                 hdr_push;
    logic                 fifo_push_ready;
    logic                 fifo_pop_valid;
    logic                 fifo_pop_ready;
    logic                 back_busy;
    logic                 emit_busy;

    assign emit_busy = back_busy || fifo_pop_valid;

    sfr_front #(
        .DATA_BYTES(DATA_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_rx_byte  (s_rx_byte),
        .emit_busy  (emit_busy),
        .payload_wr (payload_wr),
        .hdr_push   (hdr_push),
        .hdr_data   (hdr_data)
    );

    sfr_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (hdr_push),
        .push_ready (fifo_push_ready),
        .push_data  (hdr_data),
        .pop_valid  (fifo_pop_valid),
        .pop_ready  (fifo_pop_ready),
        .pop_data   (q_data)
    );

    sfr_back #(
        .DATA_BYTES(DATA_BYTES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .payload_wr     (payload_wr),
        .q_valid        (fifo_pop_valid),
        .q_ready        (fifo_pop_ready),
        .q_data         (q_data),
        .busy           (back_busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_device_type  (m_device_type),
        .m_command      (m_command),
        .m_valid_length (m_valid_length),
        .m_byte_index   (m_byte_index),
        .m_payload_byte (m_payload_byte),
        .m_last         (m_last)
    );

    `SFR_ASSERT_IMP(a_push_has_room, hdr_push, fifo_push_ready, "frame queue overflow")
    `SFR_ASSERT_ALWAYS(a_no_payload_overwrite, !(payload_wr.en && emit_busy), "payload clobbered")
    `SFR_ASSERT_NEXT(a_push_lands, hdr_push, fifo_pop_valid, "queued frame missing")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int DATA_BYTES  = 32;
    localparam int FRAME_LEN   = DATA_BYTES + 8;
    localparam int SUM_POS     = DATA_BYTES + 5;
    localparam int WORD_TARGET = 420;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_FOOT_A,
        FLAW_FOOT_B,
        FLAW_SYNC_B
    } frame_flaw_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_ALTERNATE
    } fill_t;

    typedef struct packed {
        logic [7:0] device_type;
        logic [7:0] command;
        logic [7:0] valid_length;
        logic [4:0] byte_index;
        logic [7:0] payload_byte;
        logic       last;
    } payload_word_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_req_type;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_device_type;
    logic [7:0] m_command;
    logic [7:0] m_valid_length;
    logic [4:0] m_byte_index;
    logic [7:0] m_payload_byte;
    logic       m_last;

    sync_frame_receiver_checksum_core #(
        .DATA_BYTES(DATA_BYTES)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_device_type (m_device_type),
        .m_command     (m_command),
        .m_valid_length(m_valid_length),
        .m_byte_index  (m_byte_index),
        .m_payload_byte(m_payload_byte),
        .m_last        (m_last)
    );

    // receiver shadow state
    logic [5:0]    rx_pos;
    logic [7:0]    rx_store [FRAME_LEN];
    logic [7:0]    rx_sum;
    logic          frame_waiting;
    payload_word_t payload_due [$];

    int words_sent   = 0;
    int mismatches   = 0;
    int hold_request = 0;
    bit send_gaps    = 1'b1;
    bit recv_gaps    = 1'b1;

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void track_rx_word(logic req, logic [7:0] b);
        int p;
        bit good;
        if (req == sfr_pkg::REQ_CLEAR) begin
            frame_waiting = 1'b0;
            return;
        end
        if (frame_waiting) return;
        p = rx_pos;
        if (p >= FRAME_LEN) p = 0;
        rx_store[p] = b;
        if (p < 2 && b != sfr_pkg::SYNC_BYTE) begin
            rx_pos = '0;
            rx_sum = '0;
            return;
        end
        if (p < SUM_POS) rx_sum = rx_sum + b;
        p++;
        if (p < FRAME_LEN) begin
            rx_pos = 6'(p);
            return;
        end
        good = rx_store[SUM_POS] == rx_sum && rx_store[SUM_POS + 1] == sfr_pkg::FOOT_BYTE &&
               rx_store[SUM_POS + 2] == sfr_pkg::FOOT_BYTE;
        rx_pos = '0;
        rx_sum = '0;
        if (!good) return;
        frame_waiting = 1'b1;
        for (int i = 0; i < DATA_BYTES; i++) begin
            payload_due.push_back('{rx_store[2], rx_store[3], rx_store[4], 5'(i),
                                    rx_store[5 + i], i == DATA_BYTES - 1});
        end
    endfunction

    function automatic string word_text(payload_word_t w);
        return $sformatf("type %h cmd %h len %h idx %0d data %h last %b", w.device_type,
                         w.command, w.valid_length, w.byte_index, w.payload_byte, w.last);
    endfunction

    function automatic sfr_pkg::frame_hdr_t random_header();
        return 24'($urandom);
    endfunction

    task automatic send_word(input logic req, input logic [7:0] b);
        while (send_gaps && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_rx_byte  <= b;
        do @(posedge aclk); while (!s_ready);
        track_rx_word(req, b);
        words_sent++;
    endtask

    task automatic send_frame(input frame_flaw_t flaw, input fill_t fill,
                              input sfr_pkg::frame_hdr_t hdr, input int clear_at);
        logic [7:0] rolling_sum;
        logic [7:0] pl;
        rolling_sum = sfr_pkg::SYNC_BYTE + sfr_pkg::SYNC_BYTE + hdr.device_type +
                      hdr.command + hdr.valid_length;
        send_word(sfr_pkg::REQ_RX, sfr_pkg::SYNC_BYTE);
        if (flaw == FLAW_SYNC_B) begin
            send_word(sfr_pkg::REQ_RX, sfr_pkg::SYNC_BYTE ^ 8'(1 << $urandom_range(7)));
            return;
        end
        send_word(sfr_pkg::REQ_RX, sfr_pkg::SYNC_BYTE);
        send_word(sfr_pkg::REQ_RX, hdr.device_type);
        send_word(sfr_pkg::REQ_RX, hdr.command);
        send_word(sfr_pkg::REQ_RX, hdr.valid_length);
        for (int i = 0; i < DATA_BYTES; i++) begin
            if (i == clear_at) send_word(sfr_pkg::REQ_CLEAR, 8'($urandom));
            pl = (fill == FILL_ALTERNATE) ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom);
            rolling_sum += pl;
            send_word(sfr_pkg::REQ_RX, pl);
        end
        send_word(sfr_pkg::REQ_RX,
                  flaw == FLAW_SUM ? rolling_sum ^ 8'($urandom_range(255, 1))
                                   : rolling_sum);
        send_word(sfr_pkg::REQ_RX,
                  flaw == FLAW_FOOT_A ? sfr_pkg::FOOT_BYTE ^ 8'($urandom_range(255, 1))
                                      : sfr_pkg::FOOT_BYTE);
        send_word(sfr_pkg::REQ_RX,
                  flaw == FLAW_FOOT_B ? sfr_pkg::FOOT_BYTE ^ 8'($urandom_range(255, 1))
                                      : sfr_pkg::FOOT_BYTE);
    endtask

    // clear a pending frame and walk the hunt back to position zero
    task automatic settle_receiver();
        if (frame_waiting) begin
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(3, 1)) send_word(sfr_pkg::REQ_RX, 8'($urandom));
            end
            send_word(sfr_pkg::REQ_CLEAR, 8'($urandom));
        end
        while (rx_pos != 0) send_word(sfr_pkg::REQ_RX, 8'h00);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (payload_due.size() != 0);
    endtask

    task automatic test_sync_hunt();
        send_word(sfr_pkg::REQ_RX, 8'h00);
        send_word(sfr_pkg::REQ_RX, 8'hFF);
        send_word(sfr_pkg::REQ_RX, sfr_pkg::SYNC_BYTE);
        send_word(sfr_pkg::REQ_RX, 8'h00);
        send_word(sfr_pkg::REQ_RX, sfr_pkg::SYNC_BYTE);
        send_word(sfr_pkg::REQ_RX, 8'h5F);
        send_word(sfr_pkg::REQ_CLEAR, 8'hFF);
        send_word(sfr_pkg::REQ_RX, sfr_pkg::SYNC_BYTE);
        send_word(sfr_pkg::REQ_CLEAR, 8'h00);
        send_word(sfr_pkg::REQ_RX, 8'h2F);
    endtask

    task automatic test_extreme_frame();
        send_frame(FLAW_NONE, FILL_ALTERNATE, '{8'hFF, 8'h00, 8'hFF}, -1);
    endtask

    task automatic test_pending_discard();
        send_word(sfr_pkg::REQ_RX, 8'hFF);
        send_word(sfr_pkg::REQ_RX, sfr_pkg::SYNC_BYTE);
        send_word(sfr_pkg::REQ_RX, sfr_pkg::SYNC_BYTE);
        send_word(sfr_pkg::REQ_RX, 8'h00);
        send_word(sfr_pkg::REQ_CLEAR, 8'h55);
        send_word(sfr_pkg::REQ_CLEAR, 8'hAA);
    endtask

    task automatic test_receiver_holdoff();
        hold_request = HOLD_CYCLES;
        send_frame(FLAW_NONE, FILL_RANDOM, random_header(), -1);
        settle_receiver();
        send_frame(FLAW_NONE, FILL_RANDOM, random_header(), -1);
        settle_receiver();
    endtask

    task automatic test_drain_pause();
        send_frame(FLAW_NONE, FILL_RANDOM, random_header(), -1);
        wait_drained();
        settle_receiver();
        send_frame(FLAW_NONE, FILL_RANDOM, random_header(), $urandom_range(DATA_BYTES - 1));
        settle_receiver();
    endtask

    task automatic test_no_idle_burst();
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        repeat (3) begin
            send_frame(FLAW_NONE, FILL_RANDOM, random_header(), -1);
            settle_receiver();
        end
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    task automatic test_random_traffic();
        int pick;
        while (words_sent < WORD_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                send_frame(FLAW_NONE, FILL_RANDOM, random_header(),
                           $urandom_range(6) == 0 ? $urandom_range(DATA_BYTES - 1) : -1);
            end else if (pick < 60) begin
                send_frame(FLAW_SUM, FILL_RANDOM, random_header(), -1);
            end else if (pick < 68) begin
                send_frame(FLAW_FOOT_A, FILL_RANDOM, random_header(), -1);
            end else if (pick < 76) begin
                send_frame(FLAW_FOOT_B, FILL_RANDOM, random_header(), -1);
            end else if (pick < 86) begin
                send_frame(FLAW_SYNC_B, FILL_RANDOM, random_header(), -1);
            end else if (pick < 95) begin
                repeat ($urandom_range(6, 1)) begin
                    send_word(sfr_pkg::REQ_RX,
                              $urandom_range(1) ? sfr_pkg::SYNC_BYTE : 8'($urandom));
                end
            end else begin
                send_word(sfr_pkg::REQ_CLEAR, 8'($urandom));
            end
            settle_receiver();
        end
    endtask

    // result side: random stalls plus a counted hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                m_ready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
            end else begin
                m_ready <= !(recv_gaps && $urandom_range(99) < 8);
            end
        end
    end

    always @(posedge aclk) begin
        payload_word_t got;
        payload_word_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_device_type, m_command, m_valid_length, m_byte_index,
                    m_payload_byte, m_last};
            if (payload_due.size() == 0) begin
                if (mismatches < 10) $display("unexpected word: %s", word_text(got));
                mismatches++;
            end else begin
                want = payload_due.pop_front();
                if (got !== want) begin
                    if (mismatches < 10) begin
                        $display("mismatch: expected %s", word_text(want));
                        $display("          actual   %s", word_text(got));
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_req_type    <= sfr_pkg::REQ_RX;
        s_rx_byte     <= 8'h00;
        rx_pos        = '0;
        rx_sum        = '0;
        frame_waiting = 1'b0;
        for (int i = 0; i < FRAME_LEN; i++) rx_store[i] = 8'h00;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_sync_hunt();
        test_extreme_frame();
        test_pending_discard();
        test_receiver_holdoff();
        test_drain_pause();
        test_no_idle_burst();
        test_random_traffic();

        wait_drained();
        repeat (2 * DATA_BYTES + 16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
